// ===== hw/rtl/lhg_pkg.sv =====
// shared constants and types for the load level hysteresis governor
package lhg_pkg;

  localparam int unsigned CpuW   = 12;
  localparam int unsigned FrameW = 16;
  localparam int unsigned DropW  = 10;
  localparam int unsigned MemW   = 24;
  localparam int unsigned CntW   = 11;
  localparam int unsigned CdW    = 5;
  localparam int unsigned LvlW   = 2;
  localparam int unsigned BoostW = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CntW-1:0] CntMax          = 11'd1024;
  localparam logic [CntW-1:0] EnterMedium     = 11'd4;
  localparam logic [CntW-1:0] EnterMediumFast = 11'd3;
  localparam logic [CntW-1:0] EnterHigh       = 11'd6;
  localparam logic [CntW-1:0] ExitHigh        = 11'd10;
  localparam logic [CntW-1:0] ExitMedium      = 11'd14;
  localparam logic [CdW-1:0]  TrimCooldown    = 5'd30;
  localparam logic [MemW-1:0] TrimKib         = 24'd122880;

  localparam logic [BoostW-1:0] BoostMedium    = 5'd8;
  localparam logic [BoostW-1:0] BoostMediumCpu = 5'd14;
  localparam logic [BoostW-1:0] BoostHigh      = 5'd16;
  localparam logic [BoostW-1:0] BoostHighCpu   = 5'd28;

  localparam logic [LvlW-1:0] LvlNormal = 2'd0;
  localparam logic [LvlW-1:0] LvlMedium = 2'd1;
  localparam logic [LvlW-1:0] LvlHigh   = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgCpuMed   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCpuHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameMed = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFrameHigh = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDropMed  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDropHigh = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgMemMed   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgMemHigh  = 3'd7;

  typedef struct packed {
    logic              video_active;
    logic              paused_stable;
    logic              cpu_fallback_path;
    logic [CpuW-1:0]   cpu_load_tenths;
    logic [FrameW-1:0] frame_p95_tenths;
    logic [DropW-1:0]  dropped_permille;
    logic [MemW-1:0]   private_kib;
  } sample_t;

endpackage

// ===== hw/rtl/load_level_hysteresis_governor_unit.sv =====
// load level hysteresis governor: sample register, decision logic, result register
// a word accepted into the sample register gives its result word in the result register
// throughput: one word per cycle while the output is not stalled; a sample register and a result register
//   let a new word enter while one result waits to be taken
// reset: thresholds return to defaults, counters, level and trim cooldown clear
module load_level_hysteresis_governor_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lhg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lhg_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            video_active_i,
  input  logic                            paused_stable_i,
  input  logic                            cpu_fallback_path_i,
  input  logic [lhg_pkg::CpuW-1:0]        cpu_load_tenths_i,
  input  logic [lhg_pkg::FrameW-1:0]      frame_p95_tenths_i,
  input  logic [lhg_pkg::DropW-1:0]       dropped_permille_i,
  input  logic [lhg_pkg::MemW-1:0]        private_kib_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lhg_pkg::BoostW-1:0]      sleep_boost_ms_o,
  output logic                            trim_request_o,
  output logic [lhg_pkg::LvlW-1:0]        load_level_o
);

  logic [lhg_pkg::CpuW-1:0]   cpu_med_q, cpu_high_q;
  logic [lhg_pkg::FrameW-1:0] frame_med_q, frame_high_q;
  logic [lhg_pkg::DropW-1:0]  drop_med_q, drop_high_q;
  logic [lhg_pkg::MemW-1:0]   mem_med_q, mem_high_q;

  lhg_pkg::sample_t smp_q;
  logic             smp_valid_q;
  logic             out_valid_q;

  logic [lhg_pkg::CntW-1:0] high_cnt_q, high_cnt_d;
  logic [lhg_pkg::CntW-1:0] med_cnt_q, med_cnt_d;
  logic [lhg_pkg::CntW-1:0] cool_cnt_q, cool_cnt_d;
  logic [lhg_pkg::LvlW-1:0] level_q, level_d;
  logic [lhg_pkg::CdW-1:0]  cooldown_q, cooldown_d;

  logic [lhg_pkg::BoostW-1:0] boost_q, boost_d;
  logic                       trim_q, trim_d;
  logic [lhg_pkg::LvlW-1:0]   lvl_out_q;

  logic out_free;
  logic in_acc;
  logic hi, med;
  logic [lhg_pkg::CdW-1:0] cd_dec;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = smp_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o      = out_valid_q;
  assign sleep_boost_ms_o = boost_q;
  assign trim_request_o   = trim_q;
  assign load_level_o     = lvl_out_q;

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_med_q    <= 12'd65;
      cpu_high_q   <= 12'd85;
      frame_med_q  <= 16'd80;
      frame_high_q <= 16'd100;
      drop_med_q   <= 10'd20;
      drop_high_q  <= 10'd40;
      mem_med_q    <= 24'd92160;
      mem_high_q   <= 24'd112640;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lhg_pkg::CfgCpuMed:    cpu_med_q    <= cfg_wdata_i[lhg_pkg::CpuW-1:0];
        lhg_pkg::CfgCpuHigh:   cpu_high_q   <= cfg_wdata_i[lhg_pkg::CpuW-1:0];
        lhg_pkg::CfgFrameMed:  frame_med_q  <= cfg_wdata_i[lhg_pkg::FrameW-1:0];
        lhg_pkg::CfgFrameHigh: frame_high_q <= cfg_wdata_i[lhg_pkg::FrameW-1:0];
        lhg_pkg::CfgDropMed:   drop_med_q   <= cfg_wdata_i[lhg_pkg::DropW-1:0];
        lhg_pkg::CfgDropHigh:  drop_high_q  <= cfg_wdata_i[lhg_pkg::DropW-1:0];
        lhg_pkg::CfgMemMed:    mem_med_q    <= cfg_wdata_i[lhg_pkg::MemW-1:0];
        lhg_pkg::CfgMemHigh:   mem_high_q   <= cfg_wdata_i[lhg_pkg::MemW-1:0];
        default: ;
      endcase
    end
  end

  // sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (out_free || !smp_valid_q) begin
      smp_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q.video_active      <= video_active_i;
      smp_q.paused_stable     <= paused_stable_i;
      smp_q.cpu_fallback_path <= cpu_fallback_path_i;
      smp_q.cpu_load_tenths   <= cpu_load_tenths_i;
      smp_q.frame_p95_tenths  <= frame_p95_tenths_i;
      smp_q.dropped_permille  <= dropped_permille_i;
      smp_q.private_kib       <= private_kib_i;
    end
  end

  // decision logic
  assign hi = (smp_q.cpu_load_tenths >= cpu_high_q) ||
              (smp_q.frame_p95_tenths >= frame_high_q) ||
              (smp_q.dropped_permille >= drop_high_q) ||
              (smp_q.private_kib >= mem_high_q);
  assign med = hi ||
               (smp_q.cpu_load_tenths >= cpu_med_q) ||
               (smp_q.frame_p95_tenths >= frame_med_q) ||
               (smp_q.dropped_permille >= drop_med_q) ||
               (smp_q.private_kib >= mem_med_q);
  assign cd_dec = (cooldown_q != '0) ? cooldown_q - 1'b1 : '0;

  always_comb begin
    high_cnt_d = high_cnt_q;
    med_cnt_d  = med_cnt_q;
    cool_cnt_d = cool_cnt_q;
    level_d    = level_q;
    cooldown_d = cd_dec;
    boost_d    = '0;
    trim_d     = 1'b0;

    if (!smp_q.video_active || smp_q.paused_stable) begin
      high_cnt_d = '0;
      med_cnt_d  = '0;
      cool_cnt_d = '0;
      level_d    = lhg_pkg::LvlNormal;
      cooldown_d = '0;
    end else begin
      if (hi) begin
        high_cnt_d = (high_cnt_q < lhg_pkg::CntMax) ? high_cnt_q + 1'b1 : lhg_pkg::CntMax;
        med_cnt_d  = (med_cnt_q < lhg_pkg::CntMax) ? med_cnt_q + 1'b1 : lhg_pkg::CntMax;
        cool_cnt_d = '0;
      end else if (med) begin
        med_cnt_d  = (med_cnt_q < lhg_pkg::CntMax) ? med_cnt_q + 1'b1 : lhg_pkg::CntMax;
        high_cnt_d = (high_cnt_q != '0) ? high_cnt_q - 1'b1 : '0;
        cool_cnt_d = '0;
      end else begin
        cool_cnt_d = (cool_cnt_q < lhg_pkg::CntMax) ? cool_cnt_q + 1'b1 : lhg_pkg::CntMax;
        med_cnt_d  = (med_cnt_q != '0) ? med_cnt_q - 1'b1 : '0;
        high_cnt_d = (high_cnt_q != '0) ? high_cnt_q - 1'b1 : '0;
      end

      // transitions in fixed order
      if (level_d == lhg_pkg::LvlNormal &&
          (med_cnt_d >= lhg_pkg::EnterMedium || high_cnt_d >= lhg_pkg::EnterMediumFast)) begin
        level_d    = lhg_pkg::LvlMedium;
        cool_cnt_d = '0;
      end
      if (level_d <= lhg_pkg::LvlMedium && high_cnt_d >= lhg_pkg::EnterHigh) begin
        level_d    = lhg_pkg::LvlHigh;
        cool_cnt_d = '0;
      end
      if (level_d == lhg_pkg::LvlHigh && cool_cnt_d >= lhg_pkg::ExitHigh) begin
        level_d    = lhg_pkg::LvlMedium;
        cool_cnt_d = '0;
      end
      if (level_d == lhg_pkg::LvlMedium && cool_cnt_d >= lhg_pkg::ExitMedium) begin
        level_d    = lhg_pkg::LvlNormal;
        cool_cnt_d = '0;
      end

      if (level_d >= lhg_pkg::LvlHigh) begin
        boost_d = smp_q.cpu_fallback_path ? lhg_pkg::BoostHighCpu : lhg_pkg::BoostHigh;
      end else if (level_d == lhg_pkg::LvlMedium) begin
        boost_d = smp_q.cpu_fallback_path ? lhg_pkg::BoostMediumCpu : lhg_pkg::BoostMedium;
      end

      if ((level_d != lhg_pkg::LvlNormal || med) &&
          smp_q.private_kib >= lhg_pkg::TrimKib && cd_dec == '0) begin
        trim_d     = 1'b1;
        cooldown_d = lhg_pkg::TrimCooldown;
      end
    end
  end

  // governor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_cnt_q <= '0;
      med_cnt_q  <= '0;
      cool_cnt_q <= '0;
      level_q    <= lhg_pkg::LvlNormal;
      cooldown_q <= '0;
    end else if (smp_valid_q && out_free) begin
      high_cnt_q <= high_cnt_d;
      med_cnt_q  <= med_cnt_d;
      cool_cnt_q <= cool_cnt_d;
      level_q    <= level_d;
      cooldown_q <= cooldown_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= smp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_valid_q && out_free) begin
      boost_q   <= boost_d;
      trim_q    <= trim_d;
      lvl_out_q <= level_d;
    end
  end

endmodule
